@@ hw/rtl/wav_pcm16_decode_mono_unit_assert.svh @@
// assertion macros for the wav pcm16 mono decoder
// used by the top level only, needs a clock and reset named clock and reset
`ifndef WAV_PCM16_DECODE_MONO_UNIT_ASSERT_SVH
`define WAV_PCM16_DECODE_MONO_UNIT_ASSERT_SVH

// same-cycle implication
`define WPD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wpd assertion failed");

// next-cycle implication
`define WPD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wpd assertion failed");

`endif

@@ hw/rtl/wpd_pkg.sv @@
// shared constants for the wav pcm16 mono decoder
// no dependencies
`timescale 1ns / 1ps

package wpd_pkg;

   // parse phases
   localparam logic [3:0] PH_IDLE = 4'd0;
   localparam logic [3:0] PH_HEAD = 4'd1;
   localparam logic [3:0] PH_CHDR = 4'd2;
   localparam logic [3:0] PH_FMT  = 4'd3;
   localparam logic [3:0] PH_SKIP = 4'd4;
   localparam logic [3:0] PH_DATA = 4'd5;
   localparam logic [3:0] PH_DONE = 4'd6;

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_PUT  = 2'd2;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] MIN_FILE    = 32'd44;
   localparam logic [33:0] FIRST_CHUNK = 34'd12;
   localparam logic [33:0] HDR_LEN     = 34'd8;
   localparam logic [31:0] FMT_MIN     = 32'd16;
   localparam logic [15:0] PCM_BITS    = 16'd16;
   localparam logic [15:0] FMT_PCM     = 16'd1;
   localparam logic [15:0] FMT_FLOAT   = 16'd3;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_SHORT     = 4'd1;
   localparam logic [3:0] ERR_RIFF      = 4'd2;
   localparam logic [3:0] ERR_WAVE      = 4'd3;
   localparam logic [3:0] ERR_FMT_SIZE  = 4'd4;
   localparam logic [3:0] ERR_FORMAT    = 4'd5;
   localparam logic [3:0] ERR_NO_DATA   = 4'd6;
   localparam logic [3:0] ERR_BITS      = 4'd7;
   localparam logic [3:0] ERR_ZERO_CH   = 4'd8;
   localparam logic [3:0] ERR_DATA_1ST  = 4'd9;
   localparam logic [3:0] ERR_TRUNC     = 4'd10;

   // divider: 48 bit dividend, 17 bit divisor, one quotient bit per cycle
   localparam int DIV_BITS = 48;
   localparam logic [5:0] DIV_LAST = 6'(DIV_BITS - 1);

   localparam logic DIV_FRAME = 1'b0;
   localparam logic DIV_LEN   = 1'b1;

endpackage

@@ hw/rtl/wav_pcm16_decode_mono_unit.sv @@
// wav riff pcm16 decoder with mono downmix, one file byte per request
// depends on wpd_pkg and wav_pcm16_decode_mono_unit_assert.svh
`timescale 1ns / 1ps
`include "wav_pcm16_decode_mono_unit_assert.svh"

// Usage
// req channel: one file byte per request, req_first_byte marks byte zero and
//    restarts the parse. csr register 0 (file_length) is written before a file.
// rsp channel: header, mono sample or error results, rsp_final_res on the last.
// A byte that makes no result leaves the sequencer idle. A byte that makes a
//    result goes to the put state, through the shared restoring divider first
//    when it closes a frame (division by channel count) or opens the data chunk
//    (chunk length modulo frame size).
// req_stall is high while a byte is being worked on; one byte at a time.
// The rsp output register lets a new byte in while a result waits; a second
//    result waits in the sequencer until rsp_stall drops.
// Reset clears the parse to idle, file_length to zero and drops rsp_valid.
// Bytes are ignored while idle or after the last result, until byte zero.
module wav_pcm16_decode_mono_unit import wpd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_first_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic signed [31:0] rsp_sample,
   output logic [31:0]        rsp_sample_rate,
   output logic [15:0]        rsp_channel_count,
   output logic [3:0]         rsp_error_code,
   output logic               rsp_final_res,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [1:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic [31:0] flen_ff, flen_in;
   logic [1:0]  seq_ff, seq_in;
   logic [3:0]  phase_ff, phase_in;
   logic [33:0] pos_ff, pos_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] clen_ff, clen_in;
   logic [33:0] cend_ff, cend_in;
   logic [15:0] fcode_ff, fcode_in;
   logic [15:0] chans_ff, chans_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic        fmt_found_ff, fmt_found_in;
   logic [31:0] drem_ff, drem_in;
   logic signed [32:0] fsum_ff, fsum_in;
   logic [16:0] fbytes_ff, fbytes_in;
   logic [7:0]  low_ff, low_in;
   logic [2:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [4:0]  fmt_off_ff, fmt_off_in;

   logic [16:0] div_rem_ff, div_rem_in;
   logic [47:0] div_quo_ff, div_quo_in;
   logic [16:0] div_den_ff, div_den_in;
   logic [5:0]  div_cnt_ff, div_cnt_in;
   logic        div_mode_ff, div_mode_in;
   logic        div_neg_ff, div_neg_in;

   logic [1:0]  pend_kind_ff, pend_kind_in;
   logic [3:0]  pend_err_ff, pend_err_in;
   logic        pend_fin_ff, pend_fin_in;
   logic [31:0] pend_smp_ff, pend_smp_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [31:0] rsp_smp_ff, rsp_smp_in;
   logic [31:0] rsp_rate_ff, rsp_rate_in;
   logic [15:0] rsp_ch_ff, rsp_ch_in;
   logic [3:0]  rsp_err_ff, rsp_err_in;
   logic        rsp_fin_ff, rsp_fin_in;

   logic        accept;
   logic        csr_write;

   assign req_stall  = (seq_ff != S_IDLE);
   assign accept     = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   // a single register, every word address reads it
   assign csr_prdata = (csr_paddr == 2'd0) ? flen_ff : flen_ff;

   always_comb begin
      logic [3:0]  err_v;
      logic        start_div;
      logic        hit;
      logic [33:0] flen_x;
      logic [33:0] nxt;
      logic [33:0] clen_x;
      logic [15:0] raw;
      logic [16:0] fbytes_nx;
      logic [31:0] mag;
      logic [17:0] r2;
      logic [31:0] used;
      logic [31:0] q;

      err_v     = ERR_NONE;
      start_div = 1'b0;
      hit       = 1'b0;
      flen_x    = {2'b00, flen_ff};
      nxt       = '0;
      clen_x    = '0;
      raw       = '0;
      fbytes_nx = '0;
      mag       = '0;
      r2        = '0;
      used      = '0;
      q         = '0;

      flen_in      = csr_write ? csr_pwdata : flen_ff;
      seq_in       = seq_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      tag_in       = tag_ff;
      clen_in      = clen_ff;
      cend_in      = cend_ff;
      fcode_in     = fcode_ff;
      chans_in     = chans_ff;
      rate_in      = rate_ff;
      bits_in      = bits_ff;
      fmt_found_in = fmt_found_ff;
      drem_in      = drem_ff;
      fsum_in      = fsum_ff;
      fbytes_in    = fbytes_ff;
      low_in       = low_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      fmt_off_in   = fmt_off_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_den_in   = div_den_ff;
      div_cnt_in   = div_cnt_ff;
      div_mode_in  = div_mode_ff;
      div_neg_in   = div_neg_ff;
      pend_kind_in = pend_kind_ff;
      pend_err_in  = pend_err_ff;
      pend_fin_in  = pend_fin_ff;
      pend_smp_in  = pend_smp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_smp_in   = rsp_smp_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_ch_in    = rsp_ch_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_fin_in   = rsp_fin_ff;

      case (seq_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_first_byte) begin
                  phase_in     = PH_HEAD;
                  pos_in       = '0;
                  tag_in       = '0;
                  clen_in      = '0;
                  cend_in      = '0;
                  fcode_in     = '0;
                  chans_in     = '0;
                  rate_in      = '0;
                  bits_in      = '0;
                  fmt_found_in = 1'b0;
                  drem_in      = '0;
                  fsum_in      = '0;
                  fbytes_in    = '0;
                  low_in       = '0;
                  hdr_cnt_in   = '0;
                  fmt_off_in   = '0;
                  if (flen_ff < MIN_FILE) begin
                     err_v = ERR_SHORT;
                  end
               end
               if (err_v == ERR_NONE && phase_in != PH_IDLE && phase_in != PH_DONE) begin
                  case (phase_in)
                     PH_HEAD: begin
                        tag_in = {req_data_byte, tag_in[31:8]};
                        if (pos_in == 34'd3 && tag_in != TAG_RIFF) begin
                           err_v = ERR_RIFF;
                        end else if (pos_in == 34'd11) begin
                           if (tag_in != TAG_WAVE) begin
                              err_v = ERR_WAVE;
                           end else if (FIRST_CHUNK + HDR_LEN >= flen_x) begin
                              err_v = ERR_NO_DATA;
                           end else begin
                              phase_in   = PH_CHDR;
                              cend_in    = FIRST_CHUNK + HDR_LEN;
                              tag_in     = '0;
                              clen_in    = '0;
                              hdr_cnt_in = '0;
                           end
                        end
                     end
                     PH_CHDR: begin
                        if (hdr_cnt_in < 3'd4) begin
                           tag_in = {req_data_byte, tag_in[31:8]};
                        end else begin
                           clen_in = {req_data_byte, clen_in[31:8]};
                        end
                        hdr_cnt_in = hdr_cnt_ff + 3'd1;
                        if (hdr_cnt_ff == 3'd7) begin
                           clen_x = {2'b00, clen_in};
                           nxt    = cend_in + clen_x;
                           if (tag_in == TAG_FMT) begin
                              if (clen_in < FMT_MIN || nxt > flen_x) begin
                                 err_v = ERR_FMT_SIZE;
                              end else begin
                                 cend_in    = nxt;
                                 phase_in   = PH_FMT;
                                 fmt_off_in = '0;
                              end
                           end else if (tag_in == TAG_DATA) begin
                              if (!fmt_found_in) begin
                                 err_v = ERR_DATA_1ST;
                              end else if (bits_in != PCM_BITS) begin
                                 err_v = ERR_BITS;
                              end else if (chans_in == 16'd0) begin
                                 err_v = ERR_ZERO_CH;
                              end else begin
                                 // length modulo frame size through the divider
                                 start_div   = 1'b1;
                                 div_mode_in = DIV_LEN;
                                 div_neg_in  = 1'b0;
                                 div_quo_in  = {16'd0, clen_in};
                                 div_den_in  = {chans_in, 1'b0};
                              end
                           end else begin
                              cend_in = nxt;
                              if (nxt + HDR_LEN >= flen_x) begin
                                 err_v = ERR_NO_DATA;
                              end else if (clen_in == 32'd0) begin
                                 cend_in    = nxt + HDR_LEN;
                                 tag_in     = '0;
                                 clen_in    = '0;
                                 hdr_cnt_in = '0;
                              end else begin
                                 phase_in = PH_SKIP;
                              end
                           end
                        end
                     end
                     PH_SKIP: begin
                        if (pos_in + 34'd1 >= cend_in) begin
                           if (cend_in + HDR_LEN >= flen_x) begin
                              err_v = ERR_NO_DATA;
                           end else begin
                              phase_in   = PH_CHDR;
                              cend_in    = cend_in + HDR_LEN;
                              tag_in     = '0;
                              clen_in    = '0;
                              hdr_cnt_in = '0;
                           end
                        end
                     end
                     PH_FMT: begin
                        case (fmt_off_ff)
                           5'd0: fcode_in = {8'd0, req_data_byte};
                           5'd1: begin
                              fcode_in = {req_data_byte, fcode_ff[7:0]};
                              if (fcode_in != FMT_PCM && fcode_in != FMT_FLOAT) begin
                                 err_v = ERR_FORMAT;
                              end
                           end
                           5'd2: chans_in = {8'd0, req_data_byte};
                           5'd3: chans_in = {req_data_byte, chans_ff[7:0]};
                           5'd4, 5'd5, 5'd6, 5'd7: rate_in = {req_data_byte, rate_ff[31:8]};
                           5'd14: bits_in = {8'd0, req_data_byte};
                           5'd15: begin
                              bits_in      = {req_data_byte, bits_ff[7:0]};
                              fmt_found_in = 1'b1;
                           end
                           default: ;
                        endcase
                        // offset saturates past the fields of interest
                        if (fmt_off_ff != 5'd16) begin
                           fmt_off_in = fmt_off_ff + 5'd1;
                        end
                        if (err_v == ERR_NONE && pos_in + 34'd1 >= cend_in) begin
                           if (cend_in + HDR_LEN >= flen_x) begin
                              err_v = ERR_NO_DATA;
                           end else begin
                              phase_in   = PH_CHDR;
                              cend_in    = cend_in + HDR_LEN;
                              tag_in     = '0;
                              clen_in    = '0;
                              hdr_cnt_in = '0;
                           end
                        end
                     end
                     PH_DATA: begin
                        if (!fbytes_ff[0]) begin
                           low_in = req_data_byte;
                        end else begin
                           raw     = {req_data_byte, low_ff};
                           fsum_in = fsum_ff + $signed({{17{raw[15]}}, raw});
                        end
                        fbytes_nx = fbytes_ff + 17'd1;
                        fbytes_in = fbytes_nx;
                        if (drem_ff != 32'd0) begin
                           drem_in = drem_ff - 32'd1;
                        end
                        if (fbytes_nx >= {chans_ff, 1'b0}) begin
                           // frame done: sign and magnitude into the divider
                           mag         = fsum_in[32] ? 32'(-fsum_in) : fsum_in[31:0];
                           start_div   = 1'b1;
                           div_mode_in = DIV_FRAME;
                           div_neg_in  = fsum_in[32];
                           div_quo_in  = {mag, 16'd0};
                           div_den_in  = {1'b0, chans_ff};
                           pend_fin_in = (drem_in == 32'd0);
                           fsum_in     = '0;
                           fbytes_in   = '0;
                           if (drem_in == 32'd0) begin
                              phase_in = PH_DONE;
                           end
                        end
                     end
                     default: ;
                  endcase
                  pos_in = pos_in + 34'd1;
               end
               if (err_v != ERR_NONE) begin
                  phase_in     = PH_DONE;
                  pend_kind_in = KIND_ERROR;
                  pend_err_in  = err_v;
                  pend_fin_in  = 1'b1;
                  hit          = 1'b1;
               end
               if (hit) begin
                  seq_in = S_PUT;
               end else if (start_div) begin
                  seq_in     = S_DIV;
                  div_rem_in = '0;
                  div_cnt_in = '0;
               end
            end
         end
         S_DIV: begin
            r2 = {div_rem_ff, div_quo_ff[47]};
            if (r2 >= {1'b0, div_den_ff}) begin
               div_rem_in = 17'(r2 - {1'b0, div_den_ff});
               div_quo_in = {div_quo_ff[46:0], 1'b1};
            end else begin
               div_rem_in = r2[16:0];
               div_quo_in = {div_quo_ff[46:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 6'd1;
            if (div_cnt_ff == DIV_LAST) begin
               seq_in = S_PUT;
               if (div_mode_ff == DIV_FRAME) begin
                  q            = div_quo_in[31:0];
                  pend_smp_in  = div_neg_ff ? (32'd0 - q) : q;
                  pend_kind_in = KIND_SAMPLE;
                  pend_err_in  = ERR_NONE;
               end else begin
                  used = clen_ff - {15'd0, div_rem_in};
                  if (cend_ff + {2'b00, used} > flen_x) begin
                     phase_in     = PH_DONE;
                     pend_kind_in = KIND_ERROR;
                     pend_err_in  = ERR_TRUNC;
                     pend_fin_in  = 1'b1;
                  end else begin
                     drem_in      = used;
                     fsum_in      = '0;
                     fbytes_in    = '0;
                     phase_in     = (used == 32'd0) ? PH_DONE : PH_DATA;
                     pend_kind_in = KIND_HEADER;
                     pend_err_in  = ERR_NONE;
                     pend_fin_in  = (used == 32'd0);
                  end
               end
            end
         end
         S_PUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_smp_in   = (pend_kind_ff == KIND_SAMPLE) ? pend_smp_ff : 32'd0;
               rsp_rate_in  = (pend_kind_ff == KIND_HEADER) ? rate_ff : 32'd0;
               rsp_ch_in    = (pend_kind_ff == KIND_HEADER) ? chans_ff : 16'd0;
               rsp_err_in   = pend_err_ff;
               rsp_fin_in   = pend_fin_ff;
               seq_in       = S_IDLE;
            end
         end
         default: seq_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flen_ff      <= '0;
         seq_ff       <= S_IDLE;
         phase_ff     <= PH_IDLE;
         pos_ff       <= '0;
         tag_ff       <= '0;
         clen_ff      <= '0;
         cend_ff      <= '0;
         fcode_ff     <= '0;
         chans_ff     <= '0;
         rate_ff      <= '0;
         bits_ff      <= '0;
         fmt_found_ff <= 1'b0;
         drem_ff      <= '0;
         fsum_ff      <= '0;
         fbytes_ff    <= '0;
         low_ff       <= '0;
         hdr_cnt_ff   <= '0;
         fmt_off_ff   <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         flen_ff      <= flen_in;
         seq_ff       <= seq_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         tag_ff       <= tag_in;
         clen_ff      <= clen_in;
         cend_ff      <= cend_in;
         fcode_ff     <= fcode_in;
         chans_ff     <= chans_in;
         rate_ff      <= rate_in;
         bits_ff      <= bits_in;
         fmt_found_ff <= fmt_found_in;
         drem_ff      <= drem_in;
         fsum_ff      <= fsum_in;
         fbytes_ff    <= fbytes_in;
         low_ff       <= low_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         fmt_off_ff   <= fmt_off_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_den_ff   <= div_den_in;
      div_mode_ff  <= div_mode_in;
      div_neg_ff   <= div_neg_in;
      pend_kind_ff <= pend_kind_in;
      pend_err_ff  <= pend_err_in;
      pend_fin_ff  <= pend_fin_in;
      pend_smp_ff  <= pend_smp_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_smp_ff   <= rsp_smp_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_ch_ff    <= rsp_ch_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_fin_ff   <= rsp_fin_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_sample        = $signed(rsp_smp_ff);
   assign rsp_sample_rate   = rsp_rate_ff;
   assign rsp_channel_count = rsp_ch_ff;
   assign rsp_error_code    = rsp_err_ff;
   assign rsp_final_res     = rsp_fin_ff;

   `WPD_ASSERT_NOW(err_is_final, rsp_valid_ff && rsp_kind_ff == KIND_ERROR, rsp_fin_ff)
   `WPD_ASSERT_NOW(sample_no_err, rsp_valid_ff && rsp_kind_ff == KIND_SAMPLE,
                   rsp_err_ff == ERR_NONE)
   `WPD_ASSERT_NEXT(div_to_put, seq_ff == S_DIV, seq_ff == S_DIV || seq_ff == S_PUT)

endmodule
